// ----- rtl/pes_header_parser_defines.svh -----
// ---------------------------------------------------------------------------
// PES header parser - assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PES_HEADER_PARSER_DEFINES_SVH
`define PES_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define PHP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PHP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/php_pkg.sv -----
// ---------------------------------------------------------------------------
// PES header parser package
// Sizes, stream kind codes, queue record type and header helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package php_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 131072;
   localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int unsigned CMP_W = (POS_W > 18) ? POS_W : 18;
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] KIND_VIDEO   = 2'd0;
   localparam logic [1:0] KIND_AUDIO   = 2'd1;
   localparam logic [1:0] KIND_PRIVATE = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   localparam logic [1:0] TF_PTS     = 2'd2;
   localparam logic [1:0] TF_PTS_DTS = 2'd3;

   // captured header of one packet, handed from front to back
   typedef struct packed {
      logic             start_ok;
      logic [7:0]       stream_id;
      logic [15:0]      declared_length;
      logic [7:0]       flag_a;
      logic [7:0]       flag_b;
      logic [7:0]       hdr_len;
      logic [32:0]      pts;
      logic [32:0]      dts;
      logic [23:0]      rate_bits;
      logic [POS_W-1:0] size;
   } snap_type;

   function automatic logic [3:0] pts_part(input logic [7:0] fb);
      logic [3:0] n;
      case (fb[7:6])
         TF_PTS:     n = 4'd5;
         TF_PTS_DTS: n = 4'd10;
         default:    n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [4:0] rate_offset(input logic [7:0] fb);
      return 5'd9 + {1'b0, pts_part(fb)} + (fb[5] ? 5'd6 : 5'd0);
   endfunction

   // one step of the 33-bit timestamp assembler
   function automatic logic [32:0] time_step(input logic [32:0] acc, input logic [2:0] k,
                                             input logic [7:0] b);
      logic [32:0] r;
      case (k)
         3'd0:       r = {30'd0, b[3:1]};
         3'd1, 3'd3: r = {acc[24:0], b};
         default:    r = {acc[25:0], b[7:1]};
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/php_if.sv -----
// ---------------------------------------------------------------------------
// PES header parser channels
// Valid/ready channels for packet bytes in and header summaries out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface php_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface php_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  stream_kind;
   logic [7:0]  stream_id;
   logic        start_code_ok;
   logic        marker_ok;
   logic [5:0]  header_flags;
   logic [1:0]  time_flags;
   logic [32:0] pts_ticks;
   logic [32:0] dts_ticks;
   logic [17:0] es_rate_kib;
   logic [7:0]  padding_bytes;
   logic        length_matches;
   logic [17:0] payload_bytes;

   modport source (output valid, stream_kind, stream_id, start_code_ok, marker_ok,
                   header_flags, time_flags, pts_ticks, dts_ticks, es_rate_kib,
                   padding_bytes, length_matches, payload_bytes, input ready);
   modport sink   (input valid, stream_kind, stream_id, start_code_ok, marker_ok,
                   header_flags, time_flags, pts_ticks, dts_ticks, es_rate_kib,
                   padding_bytes, length_matches, payload_bytes, output ready);
endinterface

// ----- rtl/php_front.sv -----
// ---------------------------------------------------------------------------
// PES header parser front end
// Takes one byte per transfer, captures header fields by position and
// pushes the captured record on the final byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module php_front (
   input  logic                clock,
   input  logic                reset,
   php_req_if.sink             req,
   output logic                push_valid,
   input  logic                push_ready,
   output php_pkg::snap_type   push_data
);

   logic [php_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [23:0]               sc_ff, sc_in;
   logic [7:0]                id_ff, id_in;
   logic [15:0]               dl_ff, dl_in;
   logic [7:0]                fa_ff, fa_in;
   logic [7:0]                fb_ff, fb_in;
   logic [7:0]                hl_ff, hl_in;
   logic [32:0]               pts_ff, pts_in;
   logic [32:0]               dts_ff, dts_in;
   logic [23:0]               rs_ff, rs_in;
   logic                      accept;
   logic [7:0]                b;
   logic [php_pkg::CMP_W-1:0] pos_x;
   logic [php_pkg::CMP_W-1:0] ro_x;

   assign req.ready = push_ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;
   assign pos_x     = php_pkg::CMP_W'(pos_ff);
   assign ro_x      = php_pkg::CMP_W'(php_pkg::rate_offset(fb_ff));

   always_comb begin
      pos_in = pos_ff;
      sc_in  = sc_ff;
      id_in  = id_ff;
      dl_in  = dl_ff;
      fa_in  = fa_ff;
      fb_in  = fb_ff;
      hl_in  = hl_ff;
      pts_in = pts_ff;
      dts_in = dts_ff;
      rs_in  = rs_ff;
      if (pos_x < php_pkg::CMP_W'(php_pkg::MAX_PACKET_BYTES)) begin
         case (pos_x)
            php_pkg::CMP_W'(0): sc_in[23:16] = b;
            php_pkg::CMP_W'(1): sc_in[15:8]  = b;
            php_pkg::CMP_W'(2): sc_in[7:0]   = b;
            php_pkg::CMP_W'(3): id_in        = b;
            php_pkg::CMP_W'(4): dl_in[15:8]  = b;
            php_pkg::CMP_W'(5): dl_in[7:0]   = b;
            php_pkg::CMP_W'(6): fa_in        = b;
            php_pkg::CMP_W'(7): fb_in        = b;
            php_pkg::CMP_W'(8): hl_in        = b;
            default: ;
         endcase
         if (pos_x >= php_pkg::CMP_W'(9) && pos_x < php_pkg::CMP_W'(14)) begin
            pts_in = php_pkg::time_step(pts_ff, 3'(pos_x - php_pkg::CMP_W'(9)), b);
         end
         if (pos_x >= php_pkg::CMP_W'(14) && pos_x < php_pkg::CMP_W'(19)) begin
            dts_in = php_pkg::time_step(dts_ff, 3'(pos_x - php_pkg::CMP_W'(14)), b);
         end
         if (pos_x >= php_pkg::CMP_W'(9) && pos_x >= ro_x
             && pos_x < ro_x + php_pkg::CMP_W'(3)) begin
            rs_in = {rs_ff[15:0], b};
         end
         pos_in = pos_ff + php_pkg::POS_W'(1);
      end
   end

   always_comb begin
      push_valid                = accept && req.last_byte;
      push_data.start_ok        = (sc_in == 24'h000001);
      push_data.stream_id       = id_in;
      push_data.declared_length = dl_in;
      push_data.flag_a          = fa_in;
      push_data.flag_b          = fb_in;
      push_data.hdr_len         = hl_in;
      push_data.pts             = pts_in;
      push_data.dts             = dts_in;
      push_data.rate_bits       = rs_in;
      push_data.size            = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_byte)) begin
         pos_ff <= '0;
         sc_ff  <= '0;
         id_ff  <= '0;
         dl_ff  <= '0;
         fa_ff  <= '0;
         fb_ff  <= '0;
         hl_ff  <= '0;
         pts_ff <= '0;
         dts_ff <= '0;
         rs_ff  <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         sc_ff  <= sc_in;
         id_ff  <= id_in;
         dl_ff  <= dl_in;
         fa_ff  <= fa_in;
         fb_ff  <= fb_in;
         hl_ff  <= hl_in;
         pts_ff <= pts_in;
         dts_ff <= dts_in;
         rs_ff  <= rs_in;
      end
   end

endmodule

// ----- rtl/php_queue.sv -----
// ---------------------------------------------------------------------------
// PES header parser record queue
// Short FIFO of captured headers between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pes_header_parser_defines.svh"

module php_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  php_pkg::snap_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output php_pkg::snap_type pop_data
);

   php_pkg::snap_type          mem_ff [php_pkg::QDEPTH];
   logic [php_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [php_pkg::QCNT_W-1:0] count_ff;
   logic                       push_en, pop_en;

   assign push_ready = (count_ff != php_pkg::QCNT_W'(php_pkg::QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_en    = push_valid && push_ready;
   assign pop_en     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   function automatic logic [php_pkg::QPTR_W-1:0] bump(input logic [php_pkg::QPTR_W-1:0] p);
      return (p == php_pkg::QPTR_W'(php_pkg::QDEPTH - 1)) ? '0 : p + php_pkg::QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_en) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop_en) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push_en && !pop_en) begin
            count_ff <= count_ff + php_pkg::QCNT_W'(1);
         end else if (pop_en && !push_en) begin
            count_ff <= count_ff - php_pkg::QCNT_W'(1);
         end
      end
   end

   `PHP_ASSERT_IMP(a_q_cap, 1'b1, count_ff <= php_pkg::QCNT_W'(php_pkg::QDEPTH), "queue over depth")
   `PHP_ASSERT_NXT(a_q_inc, push_en && !pop_en, count_ff == $past(count_ff) + php_pkg::QCNT_W'(1), "queue count missed a push")
   `PHP_ASSERT_NXT(a_q_dec, pop_en && !push_en, count_ff == $past(count_ff) - php_pkg::QCNT_W'(1), "queue count missed a pop")

endmodule

// ----- rtl/php_back.sv -----
// ---------------------------------------------------------------------------
// PES header parser back end
// Turns a captured header into the summary and holds it in the output
// register until the transfer completes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module php_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  php_pkg::snap_type pop_data,
   php_rsp_if.source         rsp
);

   logic                      rsp_valid_ff;
   logic [1:0]                kind_ff, kind_in;
   logic [7:0]                id_ff;
   logic                      sc_ok_ff;
   logic                      marker_ff, marker_in;
   logic [5:0]                hflags_ff, hflags_in;
   logic [1:0]                tf_ff, tf_in;
   logic [32:0]               pts_ff, pts_in;
   logic [32:0]               dts_ff, dts_in;
   logic [17:0]               rate_ff, rate_in;
   logic [7:0]                pad_ff, pad_in;
   logic                      len_ok_ff, len_ok_in;
   logic [17:0]               payload_ff, payload_in;
   logic                      load;
   logic                      known;
   logic [7:0]                id;
   logic [7:0]                fb;
   logic [4:0]                head;
   logic [php_pkg::CMP_W-1:0] size_x;
   logic [php_pkg::CMP_W-1:0] need_x;
   logic [27:0]               prod;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign load      = pop_valid && pop_ready;
   assign id        = pop_data.stream_id;
   assign fb        = pop_data.flag_b;
   assign size_x    = php_pkg::CMP_W'(pop_data.size);
   assign prod      = 28'(pop_data.rate_bits[22:1]) * 28'd50;

   always_comb begin
      if (id[7:4] == 4'hE) begin
         kind_in = php_pkg::KIND_VIDEO;
      end else if (id[7:5] == 3'b110) begin
         kind_in = php_pkg::KIND_AUDIO;
      end else if (id == 8'hBD) begin
         kind_in = php_pkg::KIND_PRIVATE;
      end else begin
         kind_in = php_pkg::KIND_UNKNOWN;
      end
      known = (kind_in != php_pkg::KIND_UNKNOWN);

      head = {1'b0, php_pkg::pts_part(fb)} + (fb[5] ? 5'd6 : 5'd0) + (fb[4] ? 5'd3 : 5'd0)
             + {4'd0, fb[3]} + {4'd0, fb[2]} + (fb[1] ? 5'd2 : 5'd0);
      need_x = php_pkg::CMP_W'(php_pkg::rate_offset(fb)) + php_pkg::CMP_W'(3);

      marker_in = 1'b0;
      hflags_in = '0;
      tf_in     = '0;
      pts_in    = '0;
      dts_in    = '0;
      rate_in   = '0;
      pad_in    = '0;
      if (known) begin
         marker_in = (pop_data.flag_a[7:6] == 2'b10);
         hflags_in = pop_data.flag_a[5:0];
         tf_in     = fb[7:6];
         if (fb[4] && size_x >= need_x) begin
            rate_in = prod[27:10];
         end
         if (pop_data.hdr_len > {3'd0, head}) begin
            pad_in = pop_data.hdr_len - {3'd0, head};
         end
         if (fb[7] && size_x >= php_pkg::CMP_W'(14)) begin
            pts_in = pop_data.pts;
         end
         if (fb[7:6] == php_pkg::TF_PTS_DTS && size_x >= php_pkg::CMP_W'(19)) begin
            dts_in = pop_data.dts;
         end
      end else begin
         head = '0;
      end

      len_ok_in = (php_pkg::CMP_W'(pop_data.declared_length) + php_pkg::CMP_W'(6) == size_x);
      if (size_x > php_pkg::CMP_W'(9) + php_pkg::CMP_W'(head)) begin
         payload_in = 18'(size_x - php_pkg::CMP_W'(9) - php_pkg::CMP_W'(head));
      end else begin
         payload_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         id_ff      <= id;
         sc_ok_ff   <= pop_data.start_ok;
         marker_ff  <= marker_in;
         hflags_ff  <= hflags_in;
         tf_ff      <= tf_in;
         pts_ff     <= pts_in;
         dts_ff     <= dts_in;
         rate_ff    <= rate_in;
         pad_ff     <= pad_in;
         len_ok_ff  <= len_ok_in;
         payload_ff <= payload_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.stream_kind    = kind_ff;
   assign rsp.stream_id      = id_ff;
   assign rsp.start_code_ok  = sc_ok_ff;
   assign rsp.marker_ok      = marker_ff;
   assign rsp.header_flags   = hflags_ff;
   assign rsp.time_flags     = tf_ff;
   assign rsp.pts_ticks      = pts_ff;
   assign rsp.dts_ticks      = dts_ff;
   assign rsp.es_rate_kib    = rate_ff;
   assign rsp.padding_bytes  = pad_ff;
   assign rsp.length_matches = len_ok_ff;
   assign rsp.payload_bytes  = payload_ff;

endmodule

// ----- rtl/pes_header_parser.sv -----
// ---------------------------------------------------------------------------
// PES header parser
// Reads PES packet bytes and emits one header summary per packet.
// ---------------------------------------------------------------------------
// channel  dir  handshake            payload
// req_bus  in   valid/ready          data_byte, last_byte
// rsp_bus  out  valid/ready          stream summary, twelve fields
//
// One byte is taken every cycle while req_bus.ready is high.
// The summary goes through the header queue and the output register.
// Reset is synchronous; it clears all state but queue and summary data.
// req_bus.ready drops only while the two-entry header queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pes_header_parser (
   input  logic       clock,
   input  logic       reset,
   php_req_if.sink    req_bus,
   php_rsp_if.source  rsp_bus
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   php_pkg::snap_type push_data, pop_data;

   php_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   php_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   php_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_bus)
   );

endmodule

// ----- tb/pes_header_parser_tb.sv -----
// ---------------------------------------------------------------------------
// PES header parser testbench
// Streams PES packets into the parser a byte per transfer, takes each header
// summary from a local parser model or a typed list and checks it field by
// field, under source gaps, sink back-pressure and one long sink hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pes_header_parser_tb;

   localparam logic [1:0] TF_FORBIDDEN  = 2'd1;
   localparam logic [7:0] ID_PRIVATE_1  = 8'hBD;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned PHASE_BYTES   = 200;
   localparam int unsigned PHASE_PACKETS = 8;
   localparam int unsigned DIR_ROWS      = 24;
   localparam int unsigned MAX_REPORTS   = 100;

   typedef struct packed {
      logic [1:0]  stream_kind;
      logic [7:0]  stream_id;
      logic        start_code_ok;
      logic        marker_ok;
      logic [5:0]  header_flags;
      logic [1:0]  time_flags;
      logic [32:0] pts_ticks;
      logic [32:0] dts_ticks;
      logic [17:0] es_rate_kib;
      logic [7:0]  padding_bytes;
      logic        length_matches;
      logic [17:0] payload_bytes;
   } summary_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
   } stim_row_type;

   logic clock;
   logic reset;

   php_req_if req_bus ();
   php_rsp_if rsp_bus ();

   pes_header_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // local parser state
   int unsigned rx_count;
   logic [23:0] sc_word;
   logic [7:0]  sid;
   logic [15:0] len_field;
   logic [7:0]  flags_a;
   logic [7:0]  flags_b;
   logic [7:0]  hdr_len;
   logic [32:0] pts_acc;
   logic [32:0] dts_acc;
   logic [23:0] rate_acc;

   summary_type due_summaries [$];
   summary_type typed_summaries [$];
   int unsigned mismatches = 0;

   int unsigned src_idle_pct = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned hold_req = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   // unknown stream after reset; private stream with forbidden time flags;
   // video with every flag set, cut short before the DTS
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{8'h00, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
      '{8'hBD, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0},
      '{8'h3F, 1'b0, 1'b0}, '{8'h5F, 1'b0, 1'b0}, '{8'h0F, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
      '{8'hEF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'hBF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned opt_time_bytes(input logic [7:0] fb);
      case (fb[7:6])
         php_pkg::TF_PTS:     return 5;
         php_pkg::TF_PTS_DTS: return 10;
         default:             return 0;
      endcase
   endfunction

   function automatic int unsigned rate_start(input logic [7:0] fb);
      return 9 + opt_time_bytes(fb) + (fb[5] ? 6 : 0);
   endfunction

   function automatic int unsigned header_opt_bytes(input logic [7:0] fb);
      return rate_start(fb) - 9 + (fb[4] ? 3 : 0) + (fb[3] ? 1 : 0)
             + (fb[2] ? 1 : 0) + (fb[1] ? 2 : 0);
   endfunction

   // 3 + 8 + 7 + 8 + 7 bits of a 33-bit timestamp, markers dropped
   function automatic logic [32:0] ts_shift(input logic [32:0] acc, input int unsigned k,
                                            input logic [7:0] b);
      case (k)
         0:       return 33'(b[3:1]);
         1, 3:    return (acc << 8) | 33'(b);
         default: return (acc << 7) | 33'(b >> 1);
      endcase
   endfunction

   task automatic clear_parser();
      rx_count  = 0;
      sc_word   = '0;
      sid       = '0;
      len_field = '0;
      flags_a   = '0;
      flags_b   = '0;
      hdr_len   = '0;
      pts_acc   = '0;
      dts_acc   = '0;
      rate_acc  = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic l, output bit emit,
                             output summary_type s);
      int unsigned pos;
      int unsigned ro;
      int unsigned head;
      int unsigned rate_val;
      s    = '0;
      emit = l;
      pos  = rx_count;
      ro   = rate_start(flags_b);
      if (pos < php_pkg::MAX_PACKET_BYTES) begin
         if (pos < 3) sc_word = sc_word | (24'(b) << (8 * (2 - pos)));
         else if (pos == 3) sid = b;
         else if (pos == 4) len_field = {b, 8'h00};
         else if (pos == 5) len_field[7:0] = b;
         else if (pos == 6) flags_a = b;
         else if (pos == 7) flags_b = b;
         else if (pos == 8) hdr_len = b;
         if (pos >= 9 && pos < 14) pts_acc = ts_shift(pts_acc, pos - 9, b);
         if (pos >= 14 && pos < 19) dts_acc = ts_shift(dts_acc, pos - 14, b);
         if (pos >= 9 && pos >= ro && pos < ro + 3) rate_acc = {rate_acc[15:0], b};
         rx_count = pos + 1;
      end
      if (!l) return;

      s.stream_id      = sid;
      s.start_code_ok  = (sc_word == 24'h000001);
      s.length_matches = (len_field + 32'd6 == rx_count);
      if (sid[7:4] == 4'hE) s.stream_kind = php_pkg::KIND_VIDEO;
      else if (sid[7:5] == 3'b110) s.stream_kind = php_pkg::KIND_AUDIO;
      else if (sid == ID_PRIVATE_1) s.stream_kind = php_pkg::KIND_PRIVATE;
      else s.stream_kind = php_pkg::KIND_UNKNOWN;

      head = 0;
      if (s.stream_kind != php_pkg::KIND_UNKNOWN) begin
         head           = header_opt_bytes(flags_b);
         s.marker_ok    = (flags_a[7:6] == 2'b10);
         s.header_flags = flags_a[5:0];
         s.time_flags   = flags_b[7:6];
         if (flags_b[4] && rx_count >= rate_start(flags_b) + 3) begin
            rate_val      = 32'(rate_acc[22:1]);
            s.es_rate_kib = 18'(rate_val * 50 / 1024);
         end
         if (hdr_len > head) s.padding_bytes = 8'(hdr_len - head);
         if (flags_b[7] && rx_count >= 14) s.pts_ticks = pts_acc;
         if (flags_b[7:6] == php_pkg::TF_PTS_DTS && rx_count >= 19) s.dts_ticks = dts_acc;
      end
      if (rx_count > 9 + head) s.payload_bytes = 18'(rx_count - 9 - head);
      clear_parser();
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [32:0] got,
                              input logic [32:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   task automatic put_byte(input logic [7:0] b, input logic l, input bit typed);
      bit          emit;
      summary_type s;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= l;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      parse_byte(b, l, emit, s);
      if (emit) begin
         if (typed) due_summaries.push_back(typed_summaries.pop_front());
         else due_summaries.push_back(s);
      end
   endtask

   // total_len = 0 gives a short random payload, otherwise fills to that size
   task automatic make_packet(ref logic [7:0] pkt [$], input int unsigned total_len,
                              input bit clean);
      logic [7:0]  fb;
      logic [7:0]  hdr;
      int unsigned opt_len;
      int unsigned len_val;
      int unsigned cut;
      pkt.delete();
      if (!clean && $urandom_range(99) < 10) begin
         repeat ($urandom_range(24, 1)) pkt.push_back(8'($urandom));
         return;
      end
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back(8'h01);
      case ($urandom_range(3))
         0:       pkt.push_back({4'hE, 4'($urandom)});
         1:       pkt.push_back({3'b110, 5'($urandom)});
         2:       pkt.push_back(ID_PRIVATE_1);
         default: pkt.push_back(8'($urandom));
      endcase
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      if ($urandom_range(99) < 85) pkt.push_back({2'b10, 6'($urandom)});
      else pkt.push_back(8'($urandom));
      fb      = 8'($urandom);
      opt_len = header_opt_bytes(fb);
      pkt.push_back(fb);
      if ($urandom_range(9) == 0) hdr = 8'($urandom);
      else hdr = 8'(opt_len + $urandom_range(4));
      pkt.push_back(hdr);
      repeat (opt_len) pkt.push_back(8'($urandom));
      if (hdr > opt_len) repeat (hdr - opt_len) pkt.push_back(8'hFF);
      if (total_len == 0) repeat ($urandom_range(8)) pkt.push_back(8'($urandom));
      else while (pkt.size() < total_len) pkt.push_back(8'($urandom));
      if (!clean && $urandom_range(99) < 10) begin
         cut = $urandom_range(pkt.size(), 1);
         while (pkt.size() > cut) void'(pkt.pop_back());
      end
      if (clean || $urandom_range(99) < 80) len_val = pkt.size() - 6;
      else len_val = $urandom;
      if (pkt.size() > 5) begin
         pkt[4] = len_val[15:8];
         pkt[5] = len_val[7:0];
      end
   endtask

   task automatic send_packet(ref logic [7:0] pkt [$]);
      foreach (pkt[i]) put_byte(pkt[i], i == pkt.size() - 1, 1'b0);
   endtask

   task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct);
      int unsigned sent_bytes = 0;
      int unsigned sent_packets = 0;
      logic [7:0]  pkt [$];
      src_idle_pct = src_pct;
      sink_stall_pct <= sink_pct;
      while (sent_bytes < PHASE_BYTES || sent_packets < PHASE_PACKETS) begin
         make_packet(pkt, 0, 1'b0);
         send_packet(pkt);
         sent_bytes += pkt.size();
         sent_packets++;
      end
   endtask

   // sink side: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_rsp
      summary_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (due_summaries.size() == 0) begin
            report_mismatch("summary transfer with none outstanding");
         end else begin
            want = due_summaries.pop_front();
            check_field("stream_kind", rsp_bus.stream_kind, want.stream_kind);
            check_field("stream_id", rsp_bus.stream_id, want.stream_id);
            check_field("start_code_ok", rsp_bus.start_code_ok, want.start_code_ok);
            check_field("marker_ok", rsp_bus.marker_ok, want.marker_ok);
            check_field("header_flags", rsp_bus.header_flags, want.header_flags);
            check_field("time_flags", rsp_bus.time_flags, want.time_flags);
            check_field("pts_ticks", rsp_bus.pts_ticks, want.pts_ticks);
            check_field("dts_ticks", rsp_bus.dts_ticks, want.dts_ticks);
            check_field("es_rate_kib", rsp_bus.es_rate_kib, want.es_rate_kib);
            check_field("padding_bytes", rsp_bus.padding_bytes, want.padding_bytes);
            check_field("length_matches", rsp_bus.length_matches, want.length_matches);
            check_field("payload_bytes", rsp_bus.payload_bytes, want.payload_bytes);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] pkt [$];
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      reset             = 1'b1;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      typed_summaries.push_back('{stream_kind: php_pkg::KIND_UNKNOWN, default: '0});
      typed_summaries.push_back('{stream_kind: php_pkg::KIND_PRIVATE,
                                  stream_id: ID_PRIVATE_1,
                                  start_code_ok: 1'b1, header_flags: 6'h3F,
                                  time_flags: TF_FORBIDDEN, padding_bytes: 8'd8,
                                  length_matches: 1'b1, default: '0});
      foreach (dir_rows[i]) put_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed);

      run_phase(0, 0);
      run_phase(47, 0);
      run_phase(0, 47);
      run_phase(17, 17);

      // sink holds off while packets keep coming, so the input must stall
      src_idle_pct = 0;
      sink_stall_pct <= 0;
      hold_req <= hold_req + 1;
      repeat (12) begin
         make_packet(pkt, 0, 1'b0);
         send_packet(pkt);
      end
      req_bus.valid <= 1'b0;

      while (due_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("pes_header_parser_tb: clean");
      end else begin
         $display("pes_header_parser_tb: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("pes_header_parser_tb: errors");
      $finish;
   end

endmodule
